// ===== hw/rtl/cgmq_pkg.sv =====
// shared types, codes and helpers for the credit gated message queue
`default_nettype none

package cgmq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    localparam int PRIO_W    = 6;
    localparam int WAIT_W    = 5;
    localparam int RUN_W     = 8;
    localparam int ACTIVE_W  = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [PRIO_W-1:0]   PRIO_MAX   = 6'd63;
    localparam logic [ACTIVE_W-1:0] ACTIVE_MAX = 9'd511;
    localparam logic [RUN_W-1:0]    RUN_MAX    = 8'd255;

    typedef enum logic [0:0] {
        OP_ENQUEUE  = 1'b0,
        OP_COMPLETE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_REFUSED   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACHED       = 2'd0,
        CFG_SERIAL_MODE    = 2'd1,
        CFG_INFLIGHT_LIMIT = 2'd2,
        CFG_QUEUE_LIMIT    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              attached;
        logic              serial_mode;
        logic [RUN_W-1:0]  inflight_limit;
        logic [WAIT_W-1:0] queue_limit;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [31:0]        payload;
        logic signed [7:0]  priority_req;
        logic               sink_refuses;
    } item_t;

    // outcome of one step, minus the head entry read from the store
    typedef struct packed {
        status_t             status;
        logic                dispatch_valid;
        logic                fwd;
        logic [31:0]         fwd_payload;
        logic [PRIO_W-1:0]   fwd_priority;
        logic [WAIT_W-1:0]   queued_count;
        logic [RUN_W-1:0]    running_count;
        logic [ACTIVE_W-1:0] active_count;
        logic                idle;
    } step_t;

    function automatic logic [PRIO_W-1:0] clamp_priority(input logic signed [7:0] raw);
        logic [PRIO_W-1:0] res;
        if (raw[7])
            res = '0;
        else if (raw[6])
            res = PRIO_MAX;
        else
            res = raw[PRIO_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cgmq_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module cgmq_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cgmq_ctrl.sv =====
// queue pointers, credit counters and per-step dispatch decision
`default_nettype none

module cgmq_ctrl #(
    parameter int QUEUE_DEPTH   = cgmq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = cgmq_pkg::PAYLOAD_WIDTH_DEF,
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int ENTRY_W = PAYLOAD_WIDTH + cgmq_pkg::PRIO_W
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cgmq_pkg::cfg_t     cfg,
    input  wire logic               accept,
    input  wire cgmq_pkg::item_t    item,
    output logic                    wr_en,
    output logic [PTR_W-1:0]        wr_addr,
    output logic [ENTRY_W-1:0]      wr_data,
    output logic                    rd_en,
    output logic [PTR_W-1:0]        rd_addr,
    output cgmq_pkg::step_t         step
);

    import cgmq_pkg::*;

    localparam int QCAP = (QUEUE_DEPTH > 31) ? 31 : QUEUE_DEPTH;
    localparam logic [WAIT_W-1:0] QCAP_W   = WAIT_W'(QCAP);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [WAIT_W-1:0]   waiting_reg, waiting_next;
    logic [RUN_W-1:0]    running_reg, running_next;
    logic [ACTIVE_W-1:0] active_reg, active_next;

    logic [WAIT_W-1:0]        eff_queue;
    logic [WAIT_W-1:0]        qlim;
    logic [RUN_W-1:0]         eff_inflight;
    logic [PAYLOAD_WIDTH-1:0] pay_w;
    logic [PRIO_W-1:0]        prio_c;
    logic                     try_dispatch;
    logic                     enq_ok;

    function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] i);
        logic [PTR_W-1:0] r;
        if (i == PTR_LAST)
            r = '0;
        else
            r = i + PTR_W'(1);
        return r;
    endfunction

    always_comb
    begin
        qlim = (cfg.queue_limit == '0) ? WAIT_W'(1) : cfg.queue_limit;
        eff_queue = (qlim > QCAP_W) ? QCAP_W : qlim;
        if (cfg.serial_mode)
            eff_inflight = RUN_W'(1);
        else
            eff_inflight = (cfg.inflight_limit == '0) ? RUN_W'(1) : cfg.inflight_limit;
    end

    assign pay_w   = PAYLOAD_WIDTH'(item.payload);
    assign prio_c  = clamp_priority(item.priority_req);
    assign wr_addr = tail_reg;
    assign rd_addr = head_reg;
    assign wr_data = {prio_c, pay_w};

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        waiting_next = waiting_reg;
        running_next = running_reg;
        active_next  = active_reg;
        try_dispatch = 1'b0;
        enq_ok       = 1'b0;
        rd_en        = 1'b0;

        step                = '0;
        step.status         = ST_OK;
        step.fwd_payload    = 32'(pay_w);
        step.fwd_priority   = prio_c;

        unique case (item.op)
            OP_ENQUEUE:
            begin
                if (!cfg.attached)
                    step.status = ST_NOT_READY;
                else if (waiting_reg >= eff_queue)
                    step.status = ST_OVERFLOW;
                else
                begin
                    enq_ok       = 1'b1;
                    tail_next    = next_index(tail_reg);
                    waiting_next = waiting_reg + WAIT_W'(1);
                    if (active_reg != ACTIVE_MAX)
                        active_next = active_reg + ACTIVE_W'(1);
                    try_dispatch = 1'b1;
                end
            end
            OP_COMPLETE:
            begin
                if (active_reg != '0)
                    active_next = active_reg - ACTIVE_W'(1);
                if (running_reg != '0)
                    running_next = running_reg - RUN_W'(1);
                try_dispatch = cfg.attached;
            end
        endcase

        if (try_dispatch && waiting_next != '0 && running_next < eff_inflight)
        begin
            step.dispatch_valid = 1'b1;
            // empty queue: the head entry is the one written this step
            step.fwd            = (waiting_reg == '0);
            rd_en               = accept && (waiting_reg != '0);
            head_next           = next_index(head_reg);
            waiting_next        = waiting_next - WAIT_W'(1);
            if (item.sink_refuses)
            begin
                step.status = ST_REFUSED;
                if (active_next != '0)
                    active_next = active_next - ACTIVE_W'(1);
            end
            else if (running_next != RUN_MAX)
                running_next = running_next + RUN_W'(1);
        end

        wr_en              = accept && enq_ok;
        step.queued_count  = waiting_next;
        step.running_count = running_next;
        step.active_count  = active_next;
        step.idle          = (waiting_next == '0) && (running_next == '0)
                             && (active_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            waiting_reg <= '0;
            running_reg <= '0;
            active_reg  <= '0;
        end
        else if (accept)
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            waiting_reg <= waiting_next;
            running_reg <= running_next;
            active_reg  <= active_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/credit_gated_message_queue_top.sv =====
// credit gated message queue: stream ports, config registers, output register
//
// channel  | direction | beat contents
// s_axis   | in        | one step: enqueue or completion
// m_axis   | out       | one result per step
// cfg      | in        | register index and write data
//
// an item passes through S_IDLE, where the accept updates pointers and counters
// and issues the read of the head entry, and then S_READ, where the read data
// moves into the output register; S_READ covers the registered message store port
// the store needs no clearing pass, only written entries are ever read
// a stalled m_axis holds the finished result; one more item may be taken
// and then waits with its read data until the output register frees up
`default_nettype none

module credit_gated_message_queue_top #(
    parameter int QUEUE_DEPTH   = cgmq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = cgmq_pkg::PAYLOAD_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // payload [31:0], priority_req [39:32], sink_refuses [40], zero [47:41]
    input  wire logic [47:0]                     s_axis_tdata,
    // op [0]
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // dispatch_valid [0], dispatch_payload [32:1], dispatch_priority [38:33],
    // queued_count [43:39], running_count [51:44], active_count [60:52],
    // idle [61], zero [63:62]
    output logic [63:0]                          m_axis_tdata,
    // status [1:0]
    output logic [1:0]                           m_axis_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cgmq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cgmq_pkg::CFG_DAT_W-1:0]  cfg_data
);

    import cgmq_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ENTRY_W = PAYLOAD_WIDTH + PRIO_W;

    typedef enum logic [0:0] {
        S_IDLE,
        S_READ
    } state_t;

    state_t              state_reg;
    cfg_t                cfg_reg;
    step_t               pend_reg;
    step_t               step;
    item_t               item;
    logic                accept;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic [31:0]         head_payload;
    logic [PRIO_W-1:0]   head_priority;
    logic [31:0]         out_payload;
    logic [PRIO_W-1:0]   out_priority;
    logic                load_out;

    assign item.op           = op_t'(s_axis_tuser);
    assign item.payload      = s_axis_tdata[31:0];
    assign item.priority_req = s_axis_tdata[39:32];
    assign item.sink_refuses = s_axis_tdata[40];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attached       <= 1'b0;
            cfg_reg.serial_mode    <= 1'b1;
            cfg_reg.inflight_limit <= RUN_W'(1);
            cfg_reg.queue_limit    <= WAIT_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ATTACHED:       cfg_reg.attached       <= cfg_data[0];
                CFG_SERIAL_MODE:    cfg_reg.serial_mode    <= cfg_data[0];
                CFG_INFLIGHT_LIMIT: cfg_reg.inflight_limit <= cfg_data[RUN_W-1:0];
                CFG_QUEUE_LIMIT:    cfg_reg.queue_limit    <= cfg_data[WAIT_W-1:0];
            endcase
        end
    end

    cgmq_ctrl #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .accept  (accept),
        .item    (item),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .step    (step)
    );

    cgmq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign head_payload  = 32'(rd_data[PAYLOAD_WIDTH-1:0]);
    assign head_priority = rd_data[ENTRY_W-1:PAYLOAD_WIDTH];

    always_comb
    begin
        if (!pend_reg.dispatch_valid)
        begin
            out_payload  = '0;
            out_priority = '0;
        end
        else if (pend_reg.fwd)
        begin
            out_payload  = pend_reg.fwd_payload;
            out_priority = pend_reg.fwd_priority;
        end
        else
        begin
            out_payload  = head_payload;
            out_priority = head_priority;
        end
    end

    assign load_out = (state_reg == S_READ) && (!m_axis_tvalid || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_READ;
                end
                S_READ:
                begin
                    if (load_out)
                        state_reg <= S_IDLE;
                end
            endcase

            if (load_out)
                m_axis_tvalid <= 1'b1;
            else if (m_axis_tready)
                m_axis_tvalid <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= step;
        if (load_out)
        begin
            m_axis_tuser <= pend_reg.status;
            m_axis_tdata <= {2'b00, pend_reg.idle, pend_reg.active_count,
                             pend_reg.running_count, pend_reg.queued_count,
                             out_priority, out_payload, pend_reg.dispatch_valid};
        end
    end

endmodule

`default_nettype wire

// ===== tb/credit_gated_message_queue_top_tb.sv =====
// self-checking testbench for the credit gated message queue top level
module credit_gated_message_queue_top_tb;

    import cgmq_pkg::*;

    localparam int QUEUE_SLOTS = QUEUE_DEPTH_DEF;
    localparam int RING_SLOTS  = 16;

    typedef struct {
        status_t             status;
        logic                dv;
        logic [31:0]         pay;
        logic [PRIO_W-1:0]   prio;
        logic [WAIT_W-1:0]   queued;
        logic [RUN_W-1:0]    running;
        logic [ACTIVE_W-1:0] active;
        logic                idle;
    } outcome_t;

    class dispatch_predictor;
        logic [31:0]       slot_payload [QUEUE_SLOTS];
        logic [PRIO_W-1:0] slot_prio [QUEUE_SLOTS];
        int head;
        int tail;
        int waiting;
        int running;
        int active;
        logic              attached;
        logic              serial;
        logic [RUN_W-1:0]  inflight;
        logic [WAIT_W-1:0] qlimit;
        // predicted result beats still waiting for the block's answer
        outcome_t outcome_ring [RING_SLOTS];
        int ring_wr;
        int ring_rd;
        int backlog;
        int mismatches;

        function new();
            head = 0;
            tail = 0;
            waiting = 0;
            running = 0;
            active = 0;
            attached = 1'b0;
            serial = 1'b1;
            inflight = 8'd1;
            qlimit = 5'd16;
            ring_wr = 0;
            ring_rd = 0;
            backlog = 0;
            mismatches = 0;
        endfunction

        function void note_outcome(outcome_t o);
            if (backlog == RING_SLOTS)
            begin
                $error("too many result beats outstanding");
                mismatches++;
                return;
            end
            outcome_ring[ring_wr] = o;
            ring_wr = (ring_wr + 1) % RING_SLOTS;
            backlog++;
        endfunction

        function outcome_t take_outcome();
            outcome_t o;
            o = outcome_ring[ring_rd];
            ring_rd = (ring_rd + 1) % RING_SLOTS;
            backlog--;
            return o;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_ATTACHED:       attached = val[0];
                CFG_SERIAL_MODE:    serial = val[0];
                CFG_INFLIGHT_LIMIT: inflight = val[RUN_W-1:0];
                CFG_QUEUE_LIMIT:    qlimit = val[WAIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_step(op_t op, logic [31:0] pay, logic signed [7:0] req,
                                logic refuses);
            outcome_t o;
            int lim;
            int room;
            bit try_send;
            lim = serial ? 1 : (inflight == 0 ? 1 : int'(inflight));
            room = qlimit == 0 ? 1 : (qlimit > QUEUE_SLOTS ? QUEUE_SLOTS : int'(qlimit));
            try_send = 1'b0;
            o.status = ST_OK;
            o.dv = 1'b0;
            o.pay = '0;
            o.prio = '0;
            if (op == OP_ENQUEUE)
            begin
                if (!attached)
                    o.status = ST_NOT_READY;
                else if (waiting >= room)
                    o.status = ST_OVERFLOW;
                else
                begin
                    slot_payload[tail] = pay;
                    if (req < 0)
                        slot_prio[tail] = '0;
                    else if (req > 63)
                        slot_prio[tail] = PRIO_MAX;
                    else
                        slot_prio[tail] = req[PRIO_W-1:0];
                    tail = (tail + 1) % QUEUE_SLOTS;
                    waiting++;
                    if (active < int'(ACTIVE_MAX))
                        active++;
                    try_send = 1'b1;
                end
            end
            else
            begin
                if (active > 0)
                    active--;
                if (running > 0)
                    running--;
                try_send = attached;
            end
            if (try_send && waiting > 0 && running < lim)
            begin
                o.dv = 1'b1;
                o.pay = slot_payload[head];
                o.prio = slot_prio[head];
                head = (head + 1) % QUEUE_SLOTS;
                waiting--;
                // a refused message is dropped, it never counts as running
                if (refuses)
                begin
                    o.status = ST_REFUSED;
                    if (active > 0)
                        active--;
                end
                else if (running < int'(RUN_MAX))
                    running++;
            end
            o.queued = WAIT_W'(waiting);
            o.running = RUN_W'(running);
            o.active = ACTIVE_W'(active);
            o.idle = (active == 0 && waiting == 0 && running == 0);
            note_outcome(o);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_outcome(logic [63:0] d, logic [1:0] u);
            outcome_t o;
            if (backlog == 0)
            begin
                $error("result beat arrived with nothing expected");
                mismatches++;
                return;
            end
            o = take_outcome();
            check_field("status", o.status, u);
            check_field("dispatch_valid", o.dv, d[0]);
            check_field("dispatch_payload", o.pay, d[32:1]);
            check_field("dispatch_priority", o.prio, d[38:33]);
            check_field("queued_count", o.queued, d[43:39]);
            check_field("running_count", o.running, d[51:44]);
            check_field("active_count", o.active, d[60:52]);
            check_field("idle", o.idle, d[61]);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    bit calm = 1'b0;
    bit hold_request = 1'b0;

    dispatch_predictor board = new();

    credit_gated_message_queue_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_idx_t'(cfg_index), cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                board.take_step(op_t'(s_axis_tuser), s_axis_tdata[31:0],
                                s_axis_tdata[39:32], s_axis_tdata[40]);
            if (m_axis_tvalid && m_axis_tready)
                board.match_outcome(m_axis_tdata, m_axis_tuser);
        end
    end

    // result side: random back-pressure, with one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 23);
        end
    end

    task automatic offer_step(item_t it);
        while (!calm && $urandom_range(99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, it.sink_refuses, it.priority_req, it.payload};
        s_axis_tuser <= it.op;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic settle_queue();
        @(posedge clk);
        while (board.backlog != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_config(logic [7:0] att, logic [7:0] ser, logic [7:0] lim,
                                logic [7:0] qlim);
        settle_queue();
        put_reg(CFG_ATTACHED, att);
        put_reg(CFG_SERIAL_MODE, ser);
        put_reg(CFG_INFLIGHT_LIMIT, lim);
        put_reg(CFG_QUEUE_LIMIT, qlim);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [7:0] pick_priority();
        case ($urandom_range(4))
            0:       return 8'sh80;
            1:       return 8'sh7f;
            2:       return 8'($urandom_range(0, 63));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_phase(int count, int enq_pct);
        item_t it;
        repeat (count)
        begin
            it.op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_COMPLETE;
            case ($urandom_range(9))
                0:       it.payload = '0;
                1:       it.payload = '1;
                default: it.payload = $urandom;
            endcase
            it.priority_req = pick_priority();
            it.sink_refuses = ($urandom_range(99) < 15);
            offer_step(it);
        end
        stop_sending();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // not attached: enqueue answered not ready, spurious completion
        offer_step('{OP_ENQUEUE, 32'hffff_ffff, 8'sh80, 1'b0});
        offer_step('{OP_COMPLETE, 32'h0, 8'sh00, 1'b1});
        stop_sending();
        apply_config(8'd1, 8'd1, 8'd1, 8'd16);

        // priority clamp edges, refusal flag on an enqueue left queued, refusal on completion
        offer_step('{OP_ENQUEUE, 32'hffff_ffff, 8'sh7f, 1'b0});
        offer_step('{OP_ENQUEUE, 32'h0000_0000, 8'shff, 1'b1});
        offer_step('{OP_ENQUEUE, 32'h5a5a_a5a5, 8'sh3f, 1'b0});
        offer_step('{OP_ENQUEUE, 32'ha5a5_5a5a, 8'sh40, 1'b0});
        offer_step('{OP_ENQUEUE, 32'h0000_0001, 8'sh00, 1'b0});
        offer_step('{OP_COMPLETE, 32'h0, 8'sh00, 1'b0});
        offer_step('{OP_COMPLETE, 32'h0, 8'sh00, 1'b1});
        offer_step('{OP_COMPLETE, 32'h0, 8'sh00, 1'b0});
        offer_step('{OP_COMPLETE, 32'h0, 8'sh00, 1'b0});
        offer_step('{OP_COMPLETE, 32'h0, 8'sh00, 1'b0});
        stop_sending();

        // small queue: fill past the limit to see overflow
        apply_config(8'd1, 8'd0, 8'd4, 8'd2);
        repeat (7)
            offer_step('{OP_ENQUEUE, $urandom, pick_priority(), 1'b0});
        stop_sending();

        // running above a lowered limit holds dispatch back
        apply_config(8'd1, 8'd1, 8'd1, 8'd2);
        offer_step('{OP_COMPLETE, 32'h0, 8'sh00, 1'b0});
        stop_sending();

        // detached completion frees counts without dispatching
        apply_config(8'd0, 8'd1, 8'd1, 8'd2);
        offer_step('{OP_COMPLETE, 32'h0, 8'sh00, 1'b0});
        offer_step('{OP_ENQUEUE, 32'h1234_5678, 8'sh10, 1'b0});
        stop_sending();

        apply_config(8'd1, 8'd0, 8'd0, 8'd0);
        run_phase(150, 60);
        apply_config(8'd1, 8'd0, 8'd255, 8'd16);
        run_phase(300, 85);
        apply_config(8'd1, 8'd0, 8'd255, 8'd31);
        run_phase(250, 40);

        apply_config(8'hfe | 8'd1, 8'hff, 8'd200, 8'd16);
        calm = 1'b1;
        run_phase(200, 55);
        calm = 1'b0;

        // long result stall while input keeps coming
        apply_config(8'd1, 8'd0, 8'd3, 8'd17);
        hold_request = 1'b1;
        run_phase(250, 50);

        apply_config(8'd0, 8'd0, 8'd8, 8'd16);
        run_phase(80, 50);

        repeat (4)
        begin
            apply_config({7'($urandom), 1'($urandom_range(9) != 0)},
                         {7'($urandom), 1'($urandom_range(1))},
                         $urandom_range(1) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            run_phase(200, 50);
        end

        settle_queue();
        if (board.mismatches == 0 && board.backlog == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
